[design/kbst_pkg.sv]
package kbst_pkg;

	// Field widths
	localparam int OP_W    = 3;
	localparam int CODE_W  = 25;
	localparam int POS_W   = 16;
	localparam int DELTA_W = POS_W + 1;
	localparam int STATE_W = 3;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PRESS   = 3'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
	localparam logic [OP_W-1:0] OP_QUERY   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
	localparam logic [OP_W-1:0] OP_NOP     = 3'd7;

	// Entry state codes
	localparam logic [STATE_W-1:0] ST_INVALID      = 3'd0;
	localparam logic [STATE_W-1:0] ST_REGISTERED   = 3'd1;
	localparam logic [STATE_W-1:0] ST_TRIGGERED    = 3'd2;
	localparam logic [STATE_W-1:0] ST_PRESSED      = 3'd3;
	localparam logic [STATE_W-1:0] ST_UNREGISTERED = 3'd4;
	localparam logic [STATE_W-1:0] ST_RELEASED     = 3'd5;

	// Decoded command as queued by the front
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              device;
		logic [CODE_W-1:0] code;
		logic [POS_W-1:0]  cur_x;
		logic [POS_W-1:0]  cur_y;
	} cmd_t;

	// Sequencer to table control
	typedef struct packed {
		logic              lookup;
		logic              apply;
		logic              active;
		logic [OP_W-1:0]   op;
		logic [CODE_W-1:0] code;
	} tbl_ctl_t;

	// Table lookup status
	typedef struct packed {
		logic               hit;
		logic               room;
		logic [STATE_W-1:0] state;
	} tbl_stat_t;

endpackage

[design/kbst_front.sv]
module kbst_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kbst_pkg::OP_W-1:0]       operation,
	input  logic                            device,
	input  logic [kbst_pkg::CODE_W-1:0]     input_code,
	input  logic signed [kbst_pkg::POS_W-1:0] cursor_x,
	input  logic signed [kbst_pkg::POS_W-1:0] cursor_y,
	output logic                            q_valid,
	output kbst_pkg::cmd_t                  q_data,
	input  logic                            q_pop
);

	localparam int PTR_W = $clog2(kbst_pkg::QUEUE_DEPTH);

	kbst_pkg::cmd_t         slot_q [kbst_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;
	logic                   push;
	logic [kbst_pkg::OP_W-1:0] op_c;
	kbst_pkg::cmd_t         cmd_c;

	// Classify: unused operation codes become a no-op
	always_comb begin
		if (operation <= kbst_pkg::OP_CLEAR) begin
			op_c = operation;
		end else begin
			op_c = kbst_pkg::OP_NOP;
		end
		cmd_c.op     = op_c;
		cmd_c.device = device;
		cmd_c.code   = input_code;
		cmd_c.cur_x  = cursor_x;
		cmd_c.cur_y  = cursor_y;
	end

	assign in_ready = (count_q != (PTR_W+1)'(kbst_pkg::QUEUE_DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_data   = slot_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_c;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PTR_W'(kbst_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				end
			end
			if (q_pop) begin
				if (rd_ptr_q == PTR_W'(kbst_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				end
			end
			if (push && !q_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

[design/kbst_table.sv]
module kbst_table #(
	parameter int SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kbst_pkg::tbl_ctl_t  ctl,
	output kbst_pkg::tbl_stat_t stat
);

	logic [SLOTS-1:0]                 valid_q;
	logic [SLOTS-1:0]                 match_q;
	logic [SLOTS-1:0]                 free_q;
	logic [SLOTS-1:0]                 pick;
	logic [kbst_pkg::CODE_W-1:0]      code_q  [SLOTS];
	logic [kbst_pkg::STATE_W-1:0]     state_q [SLOTS];
	logic [kbst_pkg::STATE_W-1:0]     rd_state;
	logic                             do_insert;

	// Per-entry compare, latched for the apply cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			free_q  <= '0;
		end else if (ctl.lookup) begin
			for (int i = 0; i < SLOTS; i++) begin
				match_q[i] <= valid_q[i] && (code_q[i] == ctl.code);
			end
			free_q <= ~valid_q;
		end
	end

	// Lowest free entry, one-hot
	assign pick = free_q & ((~free_q) + SLOTS'(1));

	// State of the matching entry (codes are unique per table)
	always_comb begin
		rd_state = kbst_pkg::ST_INVALID;
		for (int i = 0; i < SLOTS; i++) begin
			if (match_q[i]) begin
				rd_state = rd_state | state_q[i];
			end
		end
	end

	assign stat.hit   = |match_q;
	assign stat.room  = |free_q;
	assign stat.state = rd_state;

	assign do_insert = ctl.apply && ctl.active && (ctl.op == kbst_pkg::OP_PRESS) && !stat.hit;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.apply) begin
			case (ctl.op)
				kbst_pkg::OP_PRESS: begin
					if (do_insert) begin
						valid_q <= valid_q | pick;
					end
				end
				kbst_pkg::OP_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (state_q[i] == kbst_pkg::ST_RELEASED) begin
							valid_q[i] <= 1'b0;
						end
					end
				end
				kbst_pkg::OP_CLEAR: begin
					valid_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Entry codes and states
	always_ff @(posedge clk) begin
		for (int i = 0; i < SLOTS; i++) begin
			if (ctl.apply) begin
				case (ctl.op)
					kbst_pkg::OP_PRESS: begin
						if (do_insert && pick[i]) begin
							code_q[i]  <= ctl.code;
							state_q[i] <= kbst_pkg::ST_REGISTERED;
						end
					end
					kbst_pkg::OP_RELEASE: begin
						if (ctl.active && match_q[i]) begin
							state_q[i] <= kbst_pkg::ST_UNREGISTERED;
						end
					end
					kbst_pkg::OP_TICK: begin
						case (state_q[i])
							kbst_pkg::ST_REGISTERED:   state_q[i] <= kbst_pkg::ST_TRIGGERED;
							kbst_pkg::ST_TRIGGERED:    state_q[i] <= kbst_pkg::ST_PRESSED;
							kbst_pkg::ST_UNREGISTERED: state_q[i] <= kbst_pkg::ST_RELEASED;
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[design/kbst_back.sv]
module kbst_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  kbst_pkg::cmd_t                      q_data,
	output logic                                q_pop,
	output kbst_pkg::tbl_ctl_t                  key_ctl,
	output kbst_pkg::tbl_ctl_t                  btn_ctl,
	input  kbst_pkg::tbl_stat_t                 key_stat,
	input  kbst_pkg::tbl_stat_t                 btn_stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kbst_pkg::STATE_W-1:0]        input_state,
	output logic signed [kbst_pkg::DELTA_W-1:0] delta_x,
	output logic signed [kbst_pkg::DELTA_W-1:0] delta_y,
	output logic                                table_full
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0]                         state_q;
	kbst_pkg::cmd_t                     cmd_s1;
	logic                               exec_go;
	kbst_pkg::tbl_stat_t                sel_stat;
	logic [kbst_pkg::POS_W-1:0]         cur_x_q;
	logic [kbst_pkg::POS_W-1:0]         cur_y_q;
	logic [kbst_pkg::DELTA_W-1:0]       dlt_x_q;
	logic [kbst_pkg::DELTA_W-1:0]       dlt_y_q;
	logic [kbst_pkg::DELTA_W-1:0]       dx_new;
	logic [kbst_pkg::DELTA_W-1:0]       dy_new;
	logic                               is_tick;
	logic                               out_valid_q;
	logic [kbst_pkg::STATE_W-1:0]       state_out_q;
	logic [kbst_pkg::DELTA_W-1:0]       dx_out_q;
	logic [kbst_pkg::DELTA_W-1:0]       dy_out_q;
	logic                               full_out_q;

	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign exec_go = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign is_tick = (cmd_s1.op == kbst_pkg::OP_TICK);

	// Table control
	always_comb begin
		key_ctl.lookup = (state_q == S_LOOK);
		key_ctl.apply  = exec_go;
		key_ctl.active = !cmd_s1.device;
		key_ctl.op     = cmd_s1.op;
		key_ctl.code   = cmd_s1.code;
		btn_ctl        = key_ctl;
		btn_ctl.active = cmd_s1.device;
	end

	assign sel_stat = cmd_s1.device ? btn_stat : key_stat;

	// Cursor movement, sign-extended difference
	assign dx_new = {cmd_s1.cur_x[kbst_pkg::POS_W-1], cmd_s1.cur_x}
		- {cur_x_q[kbst_pkg::POS_W-1], cur_x_q};
	assign dy_new = {cmd_s1.cur_y[kbst_pkg::POS_W-1], cmd_s1.cur_y}
		- {cur_y_q[kbst_pkg::POS_W-1], cur_y_q};

	// Command latch
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Cursor and stored delta
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			dlt_x_q <= '0;
			dlt_y_q <= '0;
		end else if (exec_go && is_tick) begin
			cur_x_q <= cmd_s1.cur_x;
			cur_y_q <= cmd_s1.cur_y;
			dlt_x_q <= dx_new;
			dlt_y_q <= dy_new;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			if (cmd_s1.op == kbst_pkg::OP_QUERY) begin
				state_out_q <= sel_stat.state;
			end else begin
				state_out_q <= kbst_pkg::ST_INVALID;
			end
			full_out_q <= (cmd_s1.op == kbst_pkg::OP_PRESS) && !sel_stat.hit && !sel_stat.room;
			dx_out_q   <= is_tick ? dx_new : dlt_x_q;
			dy_out_q   <= is_tick ? dy_new : dlt_y_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign input_state = state_out_q;
	assign delta_x     = dx_out_q;
	assign delta_y     = dy_out_q;
	assign table_full  = full_out_q;

endmodule

[design/key_button_state_tracker.sv]
// Held-key and held-button tracker.
// Input channel (in_valid/in_ready) takes one command per transfer: press,
// release, tick, query or clear, with a device bit choosing the key table or
// the button table, a code, and the cursor position used by tick.
// Output channel (out_valid/out_ready) returns one result per command: the
// queried state (invalid otherwise), the stored mouse delta and a flag for a
// press dropped because its table had no free entry.
// Each command passes through the queue slot, the command latch, the compare
// registers and the output register. The sequencer works on one command at a
// time (pop, parallel compare of all entries, apply) before popping the next.
// A two-entry command queue sits between input and sequencer, so commands
// are still taken while a result waits on a stalled receiver; the sequencer
// holds its apply step until the output register is free, then the queue
// fills and in_ready drops.
// Reset empties both tables, zeroes cursor and delta, and clears the queue
// and output register; no sweep is needed after reset.
module key_button_state_tracker #(
	parameter int KEY_SLOTS    = 16,
	parameter int BUTTON_SLOTS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [kbst_pkg::OP_W-1:0]           operation,
	input  logic                                device,
	input  logic [kbst_pkg::CODE_W-1:0]         input_code,
	input  logic signed [kbst_pkg::POS_W-1:0]   cursor_x,
	input  logic signed [kbst_pkg::POS_W-1:0]   cursor_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kbst_pkg::STATE_W-1:0]        input_state,
	output logic signed [kbst_pkg::DELTA_W-1:0] delta_x,
	output logic signed [kbst_pkg::DELTA_W-1:0] delta_y,
	output logic                                table_full
);

	logic                q_valid;
	logic                q_pop;
	kbst_pkg::cmd_t      q_data;
	kbst_pkg::tbl_ctl_t  key_ctl;
	kbst_pkg::tbl_ctl_t  btn_ctl;
	kbst_pkg::tbl_stat_t key_stat;
	kbst_pkg::tbl_stat_t btn_stat;

	// Decode and command queue
	kbst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.device     (device),
		.input_code (input_code),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop)
	);

	// Keyboard key table
	kbst_table #(.SLOTS(KEY_SLOTS)) u_key_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (key_ctl),
		.stat   (key_stat)
	);

	// Mouse button table
	kbst_table #(.SLOTS(BUTTON_SLOTS)) u_btn_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (btn_ctl),
		.stat   (btn_stat)
	);

	// Sequencer, cursor delta and result register
	kbst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.key_ctl     (key_ctl),
		.btn_ctl     (btn_ctl),
		.key_stat    (key_stat),
		.btn_stat    (btn_stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.input_state (input_state),
		.delta_x     (delta_x),
		.delta_y     (delta_y),
		.table_full  (table_full)
	);

endmodule

[test/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_KEYS       = 16;
	localparam int N_BUTTONS    = 8;
	localparam int MAX_SLOTS    = 16;
	localparam int RANDOM_ITEMS = 800;
	localparam int IDLE_LIMIT   = 500;
	localparam int SETTLE       = 20;
	localparam int POOL_MAX     = 24;

	// first of the unused operation codes (the last one is OP_NOP)
	localparam logic [kbst_pkg::OP_W-1:0] OP_SPARE = 3'd5;

	// one held entry of a key or button table
	typedef struct {
		bit                           held;
		logic [kbst_pkg::CODE_W-1:0]  code;
		logic [kbst_pkg::STATE_W-1:0] st;
	} held_entry_t;

	// one result as seen on the output channel
	typedef struct {
		logic [kbst_pkg::STATE_W-1:0] state;
		logic [kbst_pkg::DELTA_W-1:0] dx;
		logic [kbst_pkg::DELTA_W-1:0] dy;
		logic                         full;
	} tracker_result_t;

	// directed row; reps > 1 presses consecutive codes, typed rows carry the answer
	typedef struct packed {
		logic [kbst_pkg::OP_W-1:0]    op;
		logic                         dev;
		logic [kbst_pkg::CODE_W-1:0]  code;
		logic [kbst_pkg::POS_W-1:0]   x;
		logic [kbst_pkg::POS_W-1:0]   y;
		logic [4:0]                   reps;
		logic                         typed;
		logic [kbst_pkg::STATE_W-1:0] e_state;
		logic [kbst_pkg::DELTA_W-1:0] e_dx;
		logic [kbst_pkg::DELTA_W-1:0] e_dy;
		logic                         e_full;
	} plan_row_t;

	localparam plan_row_t PLAN [25] = '{
		// empty after reset
		'{kbst_pkg::OP_QUERY, 1'b0, 25'h0000000, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		// press top code, then press it again
		'{kbst_pkg::OP_PRESS, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_PRESS, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_REGISTERED, 17'h00000, 17'h00000, 1'b0},
		// same code in the other table is absent
		'{kbst_pkg::OP_QUERY, 1'b1, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		// ticks to the cursor extremes: +32767/-32768, then -65535/+65535
		'{kbst_pkg::OP_TICK, 1'b1, 25'h0000000, 16'h7FFF, 16'h8000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h07FFF, 17'h18000, 1'b0},
		'{kbst_pkg::OP_TICK, 1'b0, 25'h0000000, 16'h8000, 16'h7FFF, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h10001, 17'h0FFFF, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_PRESSED, 17'h10001, 17'h0FFFF, 1'b0},
		// release held code, then an absent one
		'{kbst_pkg::OP_RELEASE, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h10001, 17'h0FFFF, 1'b0},
		'{kbst_pkg::OP_RELEASE, 1'b0, 25'h0000000, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h10001, 17'h0FFFF, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_UNREGISTERED, 17'h10001, 17'h0FFFF, 1'b0},
		// no movement
		'{kbst_pkg::OP_TICK, 1'b0, 25'h0000000, 16'h8000, 16'h7FFF, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_RELEASED, 17'h00000, 17'h00000, 1'b0},
		// released entry drops out: +32768/-32767
		'{kbst_pkg::OP_TICK, 1'b0, 25'h0000000, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h08000, 17'h18001, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b0, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h08000, 17'h18001, 1'b0},
		// unused operation codes
		'{OP_SPARE, 1'b1, 25'h1FFFFFF, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h08000, 17'h18001, 1'b0},
		'{kbst_pkg::OP_NOP, 1'b0, 25'h0000000, 16'h0000, 16'h0000, 5'd1, 1'b1,
			kbst_pkg::ST_INVALID, 17'h08000, 17'h18001, 1'b0},
		// fill the button table, overflow it, repeat a held code
		'{kbst_pkg::OP_PRESS, 1'b1, 25'h0000000, 16'h0000, 16'h0000, 5'd8, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_PRESS, 1'b1, 25'h1555555, 16'h0000, 16'h0000, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_PRESS, 1'b1, 25'h0000003, 16'h0000, 16'h0000, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b1, 25'h0000007, 16'h0000, 16'h0000, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_TICK, 1'b1, 25'h0AAAAAA, 16'h5A5A, 16'hA5A5, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b1, 25'h0000007, 16'h0000, 16'h0000, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		// clear ignores the device bit
		'{kbst_pkg::OP_CLEAR, 1'b1, 25'h0000000, 16'h0000, 16'h0000, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0},
		'{kbst_pkg::OP_QUERY, 1'b1, 25'h0000007, 16'h0000, 16'h0000, 5'd1, 1'b0,
			kbst_pkg::ST_INVALID, 17'h00000, 17'h00000, 1'b0}
	};

	logic                                clk        = 1'b0;
	logic                                arst_n     = 1'b0;
	logic                                in_valid   = 1'b0;
	logic                                in_ready;
	logic [kbst_pkg::OP_W-1:0]           operation  = kbst_pkg::OP_NOP;
	logic                                device     = 1'b0;
	logic [kbst_pkg::CODE_W-1:0]         input_code = '0;
	logic signed [kbst_pkg::POS_W-1:0]   cursor_x   = '0;
	logic signed [kbst_pkg::POS_W-1:0]   cursor_y   = '0;
	logic                                out_valid;
	logic                                out_ready  = 1'b0;
	logic [kbst_pkg::STATE_W-1:0]        input_state;
	logic signed [kbst_pkg::DELTA_W-1:0] delta_x;
	logic signed [kbst_pkg::DELTA_W-1:0] delta_y;
	logic                                table_full;

	// answer carried along with a typed directed row
	logic            cur_typed = 1'b0;
	tracker_result_t cur_fixed;

	// predictor state
	held_entry_t                  held_tbl [2][MAX_SLOTS];
	logic [kbst_pkg::POS_W-1:0]   last_x;
	logic [kbst_pkg::POS_W-1:0]   last_y;
	logic [kbst_pkg::DELTA_W-1:0] move_x;
	logic [kbst_pkg::DELTA_W-1:0] move_y;
	tracker_result_t              awaited [$];

	bit calm_mode [2];
	int errors = 0;
	int idle   = 0;

	always #1 clk = ~clk;

	key_button_state_tracker #(
		.KEY_SLOTS   (N_KEYS),
		.BUTTON_SLOTS(N_BUTTONS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.device     (device),
		.input_code (input_code),
		.cursor_x   (cursor_x),
		.cursor_y   (cursor_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.input_state(input_state),
		.delta_x    (delta_x),
		.delta_y    (delta_y),
		.table_full (table_full)
	);

	function automatic int slot_count(int dev);
		return (dev != 0) ? N_BUTTONS : N_KEYS;
	endfunction

	function automatic int find_held(int dev, logic [kbst_pkg::CODE_W-1:0] code);
		for (int i = 0; i < slot_count(dev); i++)
			if (held_tbl[dev][i].held && held_tbl[dev][i].code == code)
				return i;
		return -1;
	endfunction

	// Applies one command to the tracked tables and returns its result
	function automatic tracker_result_t track_item(logic [kbst_pkg::OP_W-1:0] op,
			logic dev, logic [kbst_pkg::CODE_W-1:0] code,
			logic [kbst_pkg::POS_W-1:0] x, logic [kbst_pkg::POS_W-1:0] y);
		tracker_result_t r;
		int d;
		int hit;
		d = dev ? 1 : 0;
		hit = find_held(d, code);
		r.state = kbst_pkg::ST_INVALID;
		r.full = 1'b0;
		case (op)
			kbst_pkg::OP_PRESS: begin
				if (hit < 0) begin
					r.full = 1'b1;
					for (int i = 0; i < slot_count(d); i++) begin
						if (!held_tbl[d][i].held) begin
							held_tbl[d][i].held = 1'b1;
							held_tbl[d][i].code = code;
							held_tbl[d][i].st = kbst_pkg::ST_REGISTERED;
							r.full = 1'b0;
							break;
						end
					end
				end
			end
			kbst_pkg::OP_RELEASE: begin
				if (hit >= 0)
					held_tbl[d][hit].st = kbst_pkg::ST_UNREGISTERED;
			end
			kbst_pkg::OP_TICK: begin
				// 17-bit difference of sign-extended positions never overflows
				move_x = {x[kbst_pkg::POS_W-1], x} - {last_x[kbst_pkg::POS_W-1], last_x};
				move_y = {y[kbst_pkg::POS_W-1], y} - {last_y[kbst_pkg::POS_W-1], last_y};
				last_x = x;
				last_y = y;
				for (int t = 0; t < 2; t++) begin
					for (int i = 0; i < slot_count(t); i++) begin
						if (held_tbl[t][i].held) begin
							case (held_tbl[t][i].st)
								kbst_pkg::ST_RELEASED:
									held_tbl[t][i].held = 1'b0;
								kbst_pkg::ST_REGISTERED:
									held_tbl[t][i].st = kbst_pkg::ST_TRIGGERED;
								kbst_pkg::ST_TRIGGERED:
									held_tbl[t][i].st = kbst_pkg::ST_PRESSED;
								kbst_pkg::ST_UNREGISTERED:
									held_tbl[t][i].st = kbst_pkg::ST_RELEASED;
								default: ;
							endcase
						end
					end
				end
			end
			kbst_pkg::OP_QUERY: begin
				if (hit >= 0)
					r.state = held_tbl[d][hit].st;
			end
			kbst_pkg::OP_CLEAR: begin
				for (int t = 0; t < 2; t++)
					for (int i = 0; i < MAX_SLOTS; i++)
						held_tbl[t][i].held = 1'b0;
			end
			default: ;
		endcase
		r.dx = move_x;
		r.dy = move_y;
		return r;
	endfunction

	// Wait length for one side; each side drifts in and out of gap-free stretches
	function automatic int pause_len(int side);
		if ($urandom_range(0, 31) == 0)
			calm_mode[side] = !calm_mode[side];
		return calm_mode[side] ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic logic [kbst_pkg::POS_W-1:0] pick_pos();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return raw[kbst_pkg::POS_W-1:0];
		endcase
	endfunction

	// Drive one command and hold it until the transfer
	task automatic send_item(logic [kbst_pkg::OP_W-1:0] op, logic dev,
			logic [kbst_pkg::CODE_W-1:0] code, logic [kbst_pkg::POS_W-1:0] x,
			logic [kbst_pkg::POS_W-1:0] y, logic typed, tracker_result_t fixed);
		int gap;
		gap = pause_len(0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		device     <= dev;
		input_code <= code;
		cursor_x   <= x;
		cursor_y   <= y;
		cur_typed  <= typed;
		cur_fixed  <= fixed;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Prediction on input transfers, checking on output transfers, idle watchdog
	always @(posedge clk) begin
		tracker_result_t got;
		tracker_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				got = track_item(operation, device, input_code, cursor_x, cursor_y);
				want = cur_typed ? cur_fixed : got;
				awaited = {awaited, want};
			end
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					$error("result with nothing pending: state %0d", input_state);
					errors++;
				end else begin
					want = awaited.pop_front();
					if (input_state !== want.state) begin
						$error("input_state: expected %0d, got %0d", want.state, input_state);
						errors++;
					end
					if (delta_x !== want.dx) begin
						$error("delta_x: expected %0d, got %0d", $signed(want.dx), delta_x);
						errors++;
					end
					if (delta_y !== want.dy) begin
						$error("delta_y: expected %0d, got %0d", $signed(want.dy), delta_y);
						errors++;
					end
					if (table_full !== want.full) begin
						$error("table_full: expected %0d, got %0d", want.full, table_full);
						errors++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// Receiver: random stall before each result
	initial begin
		int stall;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = pause_len(1);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Stimulus
	initial begin
		logic [kbst_pkg::CODE_W-1:0] code_pool [2][POOL_MAX];
		int                          pool_len [2];
		tracker_result_t             fx;
		logic [kbst_pkg::OP_W-1:0]   op;
		logic                        dev;
		logic [kbst_pkg::CODE_W-1:0] code;
		int                          roll;
		logic [31:0]                 raw;

		for (int t = 0; t < 2; t++)
			for (int i = 0; i < MAX_SLOTS; i++)
				held_tbl[t][i].held = 1'b0;
		last_x = '0;
		last_y = '0;
		move_x = '0;
		move_y = '0;
		cur_fixed = '{kbst_pkg::ST_INVALID, '0, '0, 1'b0};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		for (int r = 0; r < $size(PLAN); r++) begin
			fx.state = PLAN[r].e_state;
			fx.dx    = PLAN[r].e_dx;
			fx.dy    = PLAN[r].e_dy;
			fx.full  = PLAN[r].e_full;
			for (int k = 0; k < PLAN[r].reps; k++)
				send_item(PLAN[r].op, PLAN[r].dev, PLAN[r].code + k[kbst_pkg::CODE_W-1:0],
					PLAN[r].x, PLAN[r].y, PLAN[r].typed, fx);
		end

		// small code pools so presses, releases and queries meet; keys overflow 16 slots
		pool_len[0] = 22;
		pool_len[1] = 11;
		for (int t = 0; t < 2; t++) begin
			code_pool[t][0] = '0;
			code_pool[t][1] = '1;
			for (int i = 2; i < POOL_MAX; i++) begin
				raw = $urandom;
				code_pool[t][i] = raw[kbst_pkg::CODE_W-1:0];
			end
		end

		// random commands
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until the block has drained
				in_valid <= 1'b0;
				@(negedge clk);
				while (awaited.size() != 0) @(negedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 32)
				op = kbst_pkg::OP_PRESS;
			else if (roll < 47)
				op = kbst_pkg::OP_RELEASE;
			else if (roll < 60)
				op = kbst_pkg::OP_TICK;
			else if (roll < 94)
				op = kbst_pkg::OP_QUERY;
			else if (roll < 95)
				op = kbst_pkg::OP_CLEAR;
			else begin
				raw = $urandom_range(OP_SPARE, kbst_pkg::OP_NOP);
				op = raw[kbst_pkg::OP_W-1:0];
			end
			raw = $urandom_range(0, 1);
			dev = raw[0];
			if ($urandom_range(0, 99) < 88)
				code = code_pool[dev][$urandom_range(0, pool_len[dev] - 1)];
			else begin
				raw = $urandom;
				code = raw[kbst_pkg::CODE_W-1:0];
			end
			send_item(op, dev, code, pick_pos(), pick_pos(), 1'b0, fx);
		end
		in_valid <= 1'b0;

		// drain, then allow for stray results
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[files.f]
design/kbst_pkg.sv
design/kbst_front.sv
design/kbst_table.sv
design/kbst_back.sv
design/key_button_state_tracker.sv
test/tb.sv
